// ===== design/asks_pkg.sv =====
// shared types and constants of the active speaker top-k selector
// no dependencies; imported by every module of the block
package asks_pkg;

    localparam int DEF_PINS         = 32;
    localparam int DEF_MAX_SPEAKERS = 4;
    localparam int OUT_CAP          = 4;
    localparam int MASK_BITS        = 32;

    localparam logic [5:0] ONLY_TWO = 6'd2;

    localparam logic CFG_INPUT_COUNT  = 1'b0;
    localparam logic CFG_PRESENT_MASK = 1'b1;

    localparam logic MODE_REPORT = 1'b0;
    localparam logic MODE_SELECT = 1'b1;

    localparam logic signed [7:0] LEVEL_FLOOR = -8'sd127;

    typedef struct packed {
        logic              valid;
        logic signed [7:0] level;
        logic [4:0]        pin;
    } asks_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } asks_state_t;

endpackage

// ===== design/asks_level_table.sv =====
// per-pin level and speaking flag store, one write port and one scan read port
// depends on asks_pkg
module asks_level_table
    import asks_pkg::*;
#(
    parameter int DEPTH = DEF_PINS,
    parameter int IDX_W = $clog2(DEPTH)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_idx,
    input  logic signed [7:0]       wr_level,
    input  logic                    wr_speaking,
    input  logic [IDX_W-1:0]        rd_idx,
    output logic signed [7:0]       rd_level,
    output logic                    rd_speaking
);

    logic signed [7:0] level_reg [DEPTH];
    logic [DEPTH-1:0]  speaking_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                level_reg[i] <= LEVEL_FLOOR;
            end
            speaking_reg <= '0;
        end
        else if (wr_en)
        begin
            level_reg[wr_idx]    <= wr_level;
            speaking_reg[wr_idx] <= wr_speaking;
        end
    end

    assign rd_level    = level_reg[rd_idx];
    assign rd_speaking = speaking_reg[rd_idx];

endmodule

// ===== design/asks_cell.sv =====
// one rank of the insertion chain: holds one candidate, hands the displaced one on
// depends on asks_pkg
module asks_cell
    import asks_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        load,
    input  asks_entry_t cand,
    input  asks_entry_t prev_held,
    input  logic        prev_better,
    output asks_entry_t held,
    output logic        better
);

    asks_entry_t held_reg;
    asks_entry_t held_next;

    always_comb
    begin
        // strict compare keeps the earlier, lower pin on equal levels
        better = load && cand.valid &&
                 (!held_reg.valid || ($signed(cand.level) > $signed(held_reg.level)));
        held_next = held_reg;
        if (clear)
        begin
            held_next = '0;
        end
        else if (better)
        begin
            held_next = prev_better ? prev_held : cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    assign held = held_reg;

endmodule

// ===== design/active_speaker_top_k_select.sv =====
// Active speaker top-k selector.
// Level reports arrive on the s_axis channel (tuser = mode 0) and overwrite the
// level and speaking flag of their pin; a select transaction (tuser = mode 1)
// scans pins 0 .. min(input_count, pin table)-1, one pin per cycle, feeding a
// chain of sorting cells that keeps the loudest present speaking pins in order.
// Results leave on m_axis, one per selected pin, tlast on the final one; an
// empty selection gives one result with tuser (none_selected) set.
// Registers input_count and pin_present_mask are written on the cfg channel,
// which is always ready; write them only while the block is idle.
// With an input_count of two, a select keeps all present pins in pin order instead.
// The scan reads the pins through the single read port of the level table; while
// a select is scanned and its results are emitted, s_axis_tready is low.
// When the receiver stalls, results wait in the output register and the
// chain holds; level reports are accepted again once the final result sits
// in the output register.
// Reset: levels go to -127, speaking flags and registers to zero, no output.
// depends on asks_pkg, asks_level_table, asks_cell
module active_speaker_top_k_select
    import asks_pkg::*;
#(
    parameter int PINS         = DEF_PINS,
    parameter int MAX_SPEAKERS = DEF_MAX_SPEAKERS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // pin[4:0], has_level[5], level[13:6], voice_active[14]
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // selected_pin[4:0]
    output logic        m_axis_tuser,   // none_selected
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int STORE     = (PINS < MASK_BITS) ? PINS : MASK_BITS;
    localparam int IDX_W     = $clog2(STORE);
    localparam int CNT_W     = $clog2(STORE + 1);
    localparam int SPEAK_LIM = (MAX_SPEAKERS < OUT_CAP) ? MAX_SPEAKERS : OUT_CAP;
    localparam int CELLS     = (SPEAK_LIM < 2) ? 2 : SPEAK_LIM;
    localparam int EW        = $clog2(CELLS);

    // input fields
    logic [4:0]        in_pin;
    logic              in_has_level;
    logic signed [7:0] in_level;
    logic              in_voice;
    logic              in_accept;

    assign in_pin       = s_axis_tdata[4:0];
    assign in_has_level = s_axis_tdata[5];
    assign in_level     = s_axis_tdata[13:6];
    assign in_voice     = s_axis_tdata[14];
    assign in_accept    = s_axis_tvalid && s_axis_tready;

    // configuration
    logic [5:0]  input_count_reg;
    logic [31:0] present_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg  <= '0;
            present_mask_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INPUT_COUNT:  input_count_reg  <= cfg_data[5:0];
                CFG_PRESENT_MASK: present_mask_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // control state
    asks_state_t      state_reg, state_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0] scan_n_reg, scan_n_next;
    logic             all_mode_reg, all_mode_next;
    logic [EW-1:0]    emit_idx_reg, emit_idx_next;
    logic             m_valid_reg, m_valid_next;
    logic [4:0]       m_pin_reg, m_pin_next;
    logic             m_none_reg, m_none_next;
    logic             m_last_reg, m_last_next;

    // level table
    logic              tbl_wr_en;
    logic [IDX_W-1:0]  scan_idx;
    logic signed [7:0] rd_level;
    logic              rd_speaking;

    assign tbl_wr_en = in_accept && (s_axis_tuser == MODE_REPORT) && in_has_level &&
                       (6'(in_pin) < 6'(STORE));
    assign scan_idx  = scan_idx_reg[IDX_W-1:0];

    asks_level_table #(
        .DEPTH (STORE),
        .IDX_W (IDX_W)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (tbl_wr_en),
        .wr_idx      (in_pin[IDX_W-1:0]),
        .wr_level    (in_level),
        .wr_speaking (in_voice),
        .rd_idx      (scan_idx),
        .rd_level    (rd_level),
        .rd_speaking (rd_speaking)
    );

    // candidate of the current scan cycle
    logic        scan_done;
    logic        chain_load;
    logic        chain_clear;
    asks_entry_t cand;

    assign scan_done   = (scan_idx_reg == scan_n_reg);
    assign chain_load  = (state_reg == ST_SCAN) && !scan_done;
    assign chain_clear = in_accept && (s_axis_tuser == MODE_SELECT);

    always_comb
    begin
        cand.valid = present_mask_reg[5'(scan_idx)] && (all_mode_reg || rd_speaking);
        cand.level = all_mode_reg ? 8'sd0 : rd_level;
        cand.pin   = 5'(scan_idx);
    end

    // sorting chain
    asks_entry_t      held [CELLS];
    logic [CELLS-1:0] better;
    logic [CELLS-1:0] valid_vec;
    logic [CELLS-1:0] next_valid;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            asks_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .clear       (chain_clear),
                .load        (chain_load),
                .cand        (cand),
                .prev_held   ('0),
                .prev_better (1'b0),
                .held        (held[i]),
                .better      (better[i])
            );
        end
        else
        begin : g_body
            asks_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .clear       (chain_clear),
                .load        (chain_load),
                .cand        (cand),
                .prev_held   (held[i-1]),
                .prev_better (better[i-1]),
                .held        (held[i]),
                .better      (better[i])
            );
        end
        assign valid_vec[i] = held[i].valid;
    end

    assign next_valid = {1'b0, valid_vec[CELLS-1:1]};

    // sequencer and output register
    logic out_free;
    logic emit_last;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign emit_last = (emit_idx_reg == (all_mode_reg ? EW'(CELLS - 1) : EW'(SPEAK_LIM - 1))) ||
                       !next_valid[emit_idx_reg];

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        scan_n_next   = scan_n_reg;
        all_mode_next = all_mode_reg;
        emit_idx_next = emit_idx_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_pin_next    = m_pin_reg;
        m_none_next   = m_none_reg;
        m_last_next   = m_last_reg;
        s_axis_tready = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept && (s_axis_tuser == MODE_SELECT))
                begin
                    state_next    = ST_SCAN;
                    scan_idx_next = '0;
                    scan_n_next   = (input_count_reg > 6'(STORE)) ? CNT_W'(STORE)
                                                                  : CNT_W'(input_count_reg);
                    all_mode_next = (input_count_reg == ONLY_TWO);
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next    = ST_EMIT;
                    emit_idx_next = '0;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    if (!valid_vec[emit_idx_reg])
                    begin
                        // empty selection
                        m_pin_next  = '0;
                        m_none_next = 1'b1;
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        m_pin_next    = held[emit_idx_reg].pin;
                        m_none_next   = 1'b0;
                        m_last_next   = emit_last;
                        emit_idx_next = emit_idx_reg + 1'b1;
                        if (emit_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            scan_n_reg   <= '0;
            all_mode_reg <= 1'b0;
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
            m_pin_reg    <= '0;
            m_none_reg   <= 1'b0;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            scan_n_reg   <= scan_n_next;
            all_mode_reg <= all_mode_next;
            emit_idx_reg <= emit_idx_next;
            m_valid_reg  <= m_valid_next;
            m_pin_reg    <= m_pin_next;
            m_none_reg   <= m_none_next;
            m_last_reg   <= m_last_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_pin_reg};
    assign m_axis_tuser  = m_none_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== tb/active_speaker_top_k_select_test.sv =====
// self-checking testbench of active_speaker_top_k_select: level reports, selects, register
// writes over the stream and cfg channels, results checked against an in-bench speaker ranking
// depends on asks_pkg and the active_speaker_top_k_select rtl
module active_speaker_top_k_select_test;
    timeunit 1ns;
    timeprecision 1ps;
    import asks_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int SEL_LIMIT    = (DEF_MAX_SPEAKERS < OUT_CAP) ? DEF_MAX_SPEAKERS : OUT_CAP;

    typedef struct packed {
        logic [4:0] pin;
        logic       none;
        logic       last;
    } pick_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic        cfg_index     = 1'b0;
    logic [31:0] cfg_data      = '0;

    logic signed [7:0] level_mirror [DEF_PINS];
    logic              speak_mirror [DEF_PINS];
    logic [5:0]        count_mirror;
    logic [31:0]       mask_mirror;
    pick_t             expected_picks [$];

    int mismatches    = 0;
    int hold_requests = 0;
    bit steady        = 1'b0;

    active_speaker_top_k_select dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void clear_mirror();
        for (int i = 0; i < DEF_PINS; i++)
        begin
            level_mirror[i] = LEVEL_FLOOR;
            speak_mirror[i] = 1'b0;
        end
        count_mirror = '0;
        mask_mirror  = '0;
    endfunction

    function automatic void store_level(input logic [15:0] word);
        logic [4:0] p;
        p = word[4:0];
        if (word[5] && p < DEF_PINS)
        begin
            level_mirror[p] = word[13:6];
            speak_mirror[p] = word[14];
        end
    endfunction

    function automatic void add_pick(input logic [4:0] pin, input logic none,
                                     input logic last);
        pick_t p;
        p.pin  = pin;
        p.none = none;
        p.last = last;
        expected_picks = {expected_picks, p};
    endfunction

    function automatic void rank_speakers();
        int          n;
        int          cnt;
        int          best;
        logic [31:0] taken;
        int          picked [OUT_CAP];
        n = (count_mirror > DEF_PINS) ? DEF_PINS : int'(count_mirror);
        if (n > MASK_BITS)
            n = MASK_BITS;
        cnt   = 0;
        taken = '0;
        if (count_mirror == ONLY_TWO)
        begin
            for (int i = 0; i < n && cnt < OUT_CAP; i++)
                if (mask_mirror[i])
                begin
                    picked[cnt] = i;
                    cnt++;
                end
        end
        else
        begin
            for (int k = 0; k < SEL_LIMIT; k++)
            begin
                best = -1;
                for (int i = 0; i < n; i++)
                    if (mask_mirror[i] && speak_mirror[i] && !taken[i] &&
                        (best < 0 || level_mirror[i] > level_mirror[best]))
                        best = i;
                if (best < 0)
                    break;
                taken[best] = 1'b1;
                picked[cnt] = best;
                cnt++;
            end
        end
        if (cnt == 0)
            add_pick(5'd0, 1'b1, 1'b1);
        else
            for (int i = 0; i < cnt; i++)
                add_pick(picked[i][4:0], 1'b0, i == cnt - 1);
    endfunction

    function automatic logic [15:0] report_word(input logic [4:0] pin, input logic has,
                                                input logic [7:0] level, input logic va);
        return {1'b0, va, level, has, pin};
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 8'(-$urandom_range(0, 127));
            6:                return 8'h00;
            7:                return 8'hE2;
            default:          return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic mode, input logic [15:0] word);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= mode;
        do @(posedge clk); while (!s_axis_tready);
        if (mode == MODE_SELECT)
            rank_speakers();
        else
            store_level(word);
    endtask

    task automatic send_report(input logic [4:0] pin, input logic has,
                               input logic [7:0] level, input logic va);
        send_item(MODE_REPORT, report_word(pin, has, level, va));
    endtask

    task automatic send_select();
        logic [14:0] noise;
        noise = 15'($urandom);
        send_item(MODE_SELECT, {1'b0, noise});
    endtask

    task automatic send_random_item(input int select_odds);
        logic [4:0] pin;
        int         top;
        if ($urandom_range(0, select_odds - 1) == 0)
            send_select();
        else
        begin
            top = (count_mirror > DEF_PINS) ? DEF_PINS : int'(count_mirror);
            if (top > 0 && $urandom_range(0, 9) < 7)
                pin = 5'($urandom_range(0, top - 1));
            else
                pin = 5'($urandom_range(0, 31));
            send_report(pin, $urandom_range(0, 99) < 85, rand_level(),
                        $urandom_range(0, 99) < 60);
        end
    endtask

    // lower valid, wait for every outstanding result, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_INPUT_COUNT)
            count_mirror = value[5:0];
        else
            mask_mirror = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [5:0] count, input logic [31:0] mask);
        settle();
        write_reg(CFG_INPUT_COUNT, {26'd0, count});
        write_reg(CFG_PRESENT_MASK, mask);
    endtask

    task automatic configure_random();
        logic [5:0]  count;
        logic [31:0] mask;
        case ($urandom_range(0, 9))
            0:       count = 6'd0;
            1:       count = 6'd1;
            2:       count = ONLY_TWO;
            3:       count = 6'd32;
            4:       count = 6'($urandom_range(33, 63));
            default: count = 6'($urandom_range(3, 32));
        endcase
        case ($urandom_range(0, 4))
            0:       mask = 32'hFFFF_FFFF;
            1:       mask = $urandom & $urandom;
            2:       mask = 32'h0000_0000;
            default: mask = $urandom;
        endcase
        configure(count, mask);
    endtask

    task automatic test_select_after_reset();
        send_select();
    endtask

    task automatic test_level_ordering();
        configure(6'd4, 32'h0000_000F);
        send_report(5'd0, 1'b1, 8'h00, 1'b1);
        send_report(5'd1, 1'b1, 8'h81, 1'b1);
        // out-of-range levels on both ends
        send_report(5'd2, 1'b1, 8'h80, 1'b1);
        send_report(5'd3, 1'b1, 8'h7F, 1'b1);
        send_select();
        // report without a level leaves the pin alone
        send_report(5'd3, 1'b0, 8'h00, 1'b0);
        send_report(5'd0, 1'b1, 8'hEC, 1'b0);
        send_select();
        send_report(5'd1, 1'b1, 8'hF6, 1'b1);
        send_report(5'd2, 1'b1, 8'hF6, 1'b1);
        send_select();
    endtask

    task automatic test_two_pin_select_all();
        configure(ONLY_TWO, 32'hFFFF_FFFA);
        send_select();
        configure(ONLY_TWO, 32'h0000_0000);
        send_select();
        configure(ONLY_TWO, 32'hFFFF_FFFF);
        send_select();
    endtask

    task automatic test_scan_bounds();
        configure(6'd63, 32'hFFFF_FFFF);
        send_report(5'd31, 1'b1, 8'h00, 1'b1);
        send_report(5'd30, 1'b1, 8'hFF, 1'b1);
        send_select();
        configure(6'd1, 32'h0000_0001);
        send_select();
        configure(6'd32, 32'h8000_0001);
        send_select();
        configure(6'd0, 32'hFFFF_FFFF);
        send_select();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++)
        begin
            configure_random();
            repeat (55) send_random_item(6);
        end
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        configure(6'd32, 32'hFFFF_FFFF);
        repeat (40) send_random_item(5);
        settle();
        steady = 1'b0;
    endtask

    task automatic test_output_backpressure();
        configure(6'd32, 32'hFFFF_FFFF);
        hold_requests++;
        repeat (40) send_random_item(3);
        settle();
    endtask

    initial
    begin
        int stall;
        int hold_left;
        int hold_seen;
        stall     = 0;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        pick_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_picks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result transaction: pin %0d none %0b last %0b",
                             m_axis_tdata[4:0], m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = expected_picks.pop_front();
                if (m_axis_tdata[4:0] !== want.pin || m_axis_tuser !== want.none ||
                    m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display(
                            "mismatch: expected pin %0d none %0b last %0b, got %0d %0b %0b",
                            want.pin, want.none, want.last,
                            m_axis_tdata[4:0], m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("active_speaker_top_k_select regression: fail");
        $finish;
    end

    initial
    begin
        clear_mirror();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_select_after_reset();
        test_level_ordering();
        test_two_pin_select_all();
        test_scan_bounds();
        test_random_phases();
        test_steady_stream();
        test_output_backpressure();
        settle();
        if (mismatches == 0 && expected_picks.size() == 0)
            $display("active_speaker_top_k_select regression: pass");
        else
            $display("active_speaker_top_k_select regression: fail");
        $finish;
    end

endmodule
